>>> hw/rtl/lrbg_pkg.sv
// Shared types, constants and the arctangent table for the landmark gate.
// Used by every module of the landmark range / bearing gate.
package lrbg_pkg;

   localparam int PosWidth        = 24;
   localparam int DiffWidth       = 25;
   localparam int SqWidth         = 50;
   localparam int RootWidth       = 25;
   localparam int SqrtSteps       = 25;
   localparam int AngWidth        = 32;
   localparam int CordWidth       = 34;
   localparam int GuardShift      = 6;
   localparam int CordicStagesDef = 16;
   localparam int CordicStagesMax = 24;
   localparam int CsrIdxWidth     = 2;
   localparam int CsrDataWidth    = 24;
   localparam int ReqDataWidth    = 112;
   localparam int RspDataWidth    = 40;

   // register indexes on the configuration channel
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_RANGE_MIN   = 2'd0,
      CSR_RANGE_MAX   = 2'd1,
      CSR_BEARING_MIN = 2'd2,
      CSR_BEARING_MAX = 2'd3
   } csr_index_type;

   localparam logic [AngWidth-1:0] AngQuarter      = 32'h4000_0000;
   localparam logic [AngWidth-1:0] AngThreeQuarter = 32'hC000_0000;

   // atan(2^-i), one full turn is 2^32
   function automatic logic [AngWidth-1:0] atan_entry(input int i);
      logic [AngWidth-1:0] v;
      begin
         unique case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage

>>> hw/rtl/landmark_range_bearing_gate_unit.sv
// Landmark range / bearing gate: top level with window registers and pipeline control.
// Depends on lrbg_pkg, lrbg_sqrt and lrbg_cordic.
//
// Usage: each request on req_ carries a landmark and the vehicle pose; every request
// gives exactly one result on rsp_ with range, bearing in the vehicle frame, a kept
// flag (tuser) for the window test, and tlast copied through.
// Pipeline: the request is registered at the accepting edge into the first of 3 set-up
// stages, then 25 root stages and one output register follow. The CORDIC runs beside
// the root pipeline and is padded to the same depth.
// Throughput: one request per cycle while the output is not stalled, set by the
// one-bit-per-stage root pipeline.
// Stall: the whole pipeline holds while rsp_tvalid is high and rsp_tready low;
// req_tready is low in exactly those cycles, so nothing is lost or repeated.
// Reset: clears all valid bits and loads the window registers with their defaults
// (range 0..15360, bearing -9102..9102). Window registers are written on csr_
// at any cycle (always ready); they take effect for requests still to be evaluated.
module landmark_range_bearing_gate_unit
   import lrbg_pkg::*;
#(
   parameter int CORDIC_STAGES = CordicStagesDef
) (
   input  logic                    clock,
   input  logic                    reset,
   // landmark_x, landmark_y, vehicle_x, vehicle_y, vehicle_heading (low to high)
   input  logic [ReqDataWidth-1:0] req_tdata,
   input  logic                    req_tlast,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // range_out, bearing_out (low to high)
   output logic [RspDataWidth-1:0] rsp_tdata,
   // kept
   output logic                    rsp_tuser,
   output logic                    rsp_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_data
);

   localparam int PipeLen = 3 + SqrtSteps;
   localparam int PadLen  = PipeLen - 2 - CORDIC_STAGES;

   typedef struct packed {
      logic [15:0] heading;
      logic        last;
      logic        zero;
   } side_type;

   logic adv;

   // window registers
   logic [23:0] range_min_ff, range_max_ff;
   logic signed [15:0] bearing_min_ff, bearing_max_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff   <= 24'd0;
         range_max_ff   <= 24'd15360;
         bearing_min_ff <= -16'sd9102;
         bearing_max_ff <= 16'sd9102;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_RANGE_MIN:   range_min_ff   <= csr_data;
            CSR_RANGE_MAX:   range_max_ff   <= csr_data;
            CSR_BEARING_MIN: bearing_min_ff <= csr_data[15:0];
            CSR_BEARING_MAX: bearing_max_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // global advance: output register empty or being taken
   logic rsp_valid_ff;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // valid bits and side data travel together
   logic     vld_ff  [0:PipeLen-1];
   side_type side_ff [0:PipeLen-1];
   side_type side_in;

   assign side_in = '{heading: req_tdata[111:96], last: req_tlast, zero: 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PipeLen; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < PipeLen; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // stage 1: offsets
   logic signed [DiffWidth-1:0] dx_ff, dy_ff, dx_in, dy_in;
   assign dx_in = $signed({req_tdata[23], req_tdata[23:0]})
                - $signed({req_tdata[71], req_tdata[71:48]});
   assign dy_in = $signed({req_tdata[47], req_tdata[47:24]})
                - $signed({req_tdata[95], req_tdata[95:72]});

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff      <= dx_in;
         dy_ff      <= dy_in;
         side_ff[0] <= side_in;
         // zero-offset flag joins at stage 2
         side_ff[1] <= '{heading: side_ff[0].heading, last: side_ff[0].last,
                         zero: (dx_ff == '0) && (dy_ff == '0)};
         for (int k = 2; k < PipeLen; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   // stage 2: squares and quadrant pre-rotation
   logic [DiffWidth-1:0] ax, ay;
   logic [SqWidth-1:0]   sqx_ff, sqy_ff;
   logic signed [CordWidth-1:0] xe, ye, xr_in, yr_in, xr_ff, yr_ff;
   logic [AngWidth-1:0] a0_in, a0_ff;

   always_comb begin
      ax = dx_ff[DiffWidth-1] ? DiffWidth'(-dx_ff) : dx_ff;
      ay = dy_ff[DiffWidth-1] ? DiffWidth'(-dy_ff) : dy_ff;
      xe = CordWidth'(dx_ff);
      ye = CordWidth'(dy_ff);
      if (!dx_ff[DiffWidth-1]) begin
         xr_in = xe;
         yr_in = ye;
         a0_in = '0;
      end else if (!dy_ff[DiffWidth-1]) begin
         xr_in = ye;
         yr_in = -xe;
         a0_in = AngQuarter;
      end else begin
         xr_in = -ye;
         yr_in = xe;
         a0_in = AngThreeQuarter;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff <= SqWidth'(ax * ax);
         sqy_ff <= SqWidth'(ay * ay);
         xr_ff  <= xr_in <<< GuardShift;
         yr_ff  <= yr_in <<< GuardShift;
         a0_ff  <= a0_in;
      end
   end

   // stage 3: sum of squares
   logic [SqWidth-1:0] sum_ff;
   always_ff @(posedge clock) begin
      if (adv) sum_ff <= sqx_ff + sqy_ff;
   end

   logic [RootWidth-1:0] root;
   lrbg_sqrt u_sqrt (
      .clock    (clock),
      .en       (adv),
      .radicand (sum_ff),
      .root     (root)
   );

   logic [AngWidth-1:0] ang_end;
   lrbg_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
      .clock     (clock),
      .en        (adv),
      .x_start   (xr_ff),
      .y_start   (yr_ff),
      .ang_start (a0_ff),
      .ang_end   (ang_end)
   );

   // pad the angle to the depth of the root pipeline
   logic [AngWidth-1:0] pad_ff [0:PadLen-1];
   always_ff @(posedge clock) begin
      if (adv) begin
         pad_ff[0] <= ang_end;
         for (int k = 1; k < PadLen; k++) pad_ff[k] <= pad_ff[k-1];
      end
   end

   // final stage: heading, rounding, saturation and window test
   side_type            side_last;
   logic [AngWidth-1:0] ang_w, ang_rel, ang_rnd;
   logic signed [15:0]  bear;
   logic [23:0]         rng;
   logic                kept;

   always_comb begin
      side_last = side_ff[PipeLen-1];
      ang_w     = side_last.zero ? '0 : pad_ff[PadLen-1];
      ang_rel   = ang_w - {side_last.heading, 16'h0000};
      ang_rnd   = ang_rel + 32'h0000_8000;
      bear      = $signed(ang_rnd[31:16]);
      rng       = root[RootWidth-1] ? 24'hFF_FFFF : root[23:0];
      kept      = (range_min_ff <= rng) && (rng <= range_max_ff)
               && (bearing_min_ff <= bear) && (bear <= bearing_max_ff);
   end

   logic [RspDataWidth-1:0] rsp_data_ff;
   logic                    rsp_kept_ff, rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[PipeLen-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {bear, rng};
         rsp_kept_ff <= kept;
         rsp_last_ff <= side_last.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kept_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> hw/rtl/lrbg_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on lrbg_pkg.
module lrbg_sqrt
   import lrbg_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  logic [SqWidth-1:0]   radicand,
   output logic [RootWidth-1:0] root
);

   logic [SqWidth-1:0]   rem_ff  [0:SqrtSteps-1];
   logic [RootWidth-1:0] root_ff [0:SqrtSteps-1];
   logic [SqWidth-1:0]   rem_in  [0:SqrtSteps-1];
   logic [RootWidth-1:0] root_in [0:SqrtSteps-1];

   for (genvar j = 0; j < SqrtSteps; j++) begin : g_step
      localparam int B = SqrtSteps - 1 - j;
      logic [SqWidth-1:0]   rem_prev;
      logic [RootWidth-1:0] root_prev;
      logic [SqWidth:0]     trial;

      if (j == 0) begin : g_first
         assign rem_prev  = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
      end

      // try setting bit B: (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
      always_comb begin
         trial = ({{(SqWidth+1-RootWidth){1'b0}}, root_prev} << (B + 1))
               + ((SqWidth+1)'(1) << (2 * B));
         if ({1'b0, rem_prev} >= trial) begin
            rem_in[j]  = rem_prev - trial[SqWidth-1:0];
            root_in[j] = root_prev | (RootWidth'(1) << B);
         end else begin
            rem_in[j]  = rem_prev;
            root_in[j] = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
         end
      end
   end

   assign root = root_ff[SqrtSteps-1];

endmodule

>>> hw/rtl/lrbg_cordic.sv
// Pipelined vectoring CORDIC, one micro-rotation per register stage.
// Depends on lrbg_pkg for widths and the arctangent table.
module lrbg_cordic
   import lrbg_pkg::*;
#(
   parameter int CORDIC_STAGES = CordicStagesDef
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [CordWidth-1:0] x_start,
   input  logic signed [CordWidth-1:0] y_start,
   input  logic [AngWidth-1:0]        ang_start,
   output logic [AngWidth-1:0]        ang_end
);

   logic signed [CordWidth-1:0] x_ff   [0:CORDIC_STAGES-1];
   logic signed [CordWidth-1:0] y_ff   [0:CORDIC_STAGES-1];
   logic [AngWidth-1:0]         ang_ff [0:CORDIC_STAGES-1];
   logic signed [CordWidth-1:0] x_in   [0:CORDIC_STAGES-1];
   logic signed [CordWidth-1:0] y_in   [0:CORDIC_STAGES-1];
   logic [AngWidth-1:0]         ang_in [0:CORDIC_STAGES-1];

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      localparam logic [AngWidth-1:0] Atan = atan_entry(i);
      logic signed [CordWidth-1:0] xp, yp;
      logic [AngWidth-1:0]         ap;

      if (i == 0) begin : g_first
         assign xp = x_start;
         assign yp = y_start;
         assign ap = ang_start;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign ap = ang_ff[i-1];
      end

      // drive y toward zero; arithmetic shifts floor
      always_comb begin
         if (!yp[CordWidth-1]) begin
            x_in[i]   = xp + (yp >>> i);
            y_in[i]   = yp - (xp >>> i);
            ang_in[i] = ap + Atan;
         end else begin
            x_in[i]   = xp - (yp >>> i);
            y_in[i]   = yp + (xp >>> i);
            ang_in[i] = ap - Atan;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]   <= x_in[i];
            y_ff[i]   <= y_in[i];
            ang_ff[i] <= ang_in[i];
         end
      end
   end

   assign ang_end = ang_ff[CORDIC_STAGES-1];

endmodule

>>> hw/rtl/lrbg_checker.sv
// Port-level checks for the landmark range / bearing gate, bound to the top level.
// Depends on lrbg_pkg and landmark_range_bearing_gate_unit.
module lrbg_port_checker
   import lrbg_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tready,
   input logic [RspDataWidth-1:0] rsp_tdata,
   input logic                    rsp_tuser,
   input logic                    rsp_tlast,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic                    csr_ready
);

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // pipeline freezes on a stalled result: no request taken
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while result stalled");

   // an empty output register never blocks requests
   a_free_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready && csr_ready)
      else $error("ready low with empty output");

endmodule

bind landmark_range_bearing_gate_unit lrbg_port_checker u_lrbg_checker (.*);

>>> tb/lrbg_checker.sv
// Scoreboard for the landmark range / bearing gate: watches the request, response and
// register channels, predicts each response and compares it field by field.
// Depends on lrbg_pkg for widths and register indexes.
module lrbg_checker
   import lrbg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [ReqDataWidth-1:0] req_tdata,
   input  logic                    req_tlast,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [RspDataWidth-1:0] rsp_tdata,
   input  logic                    rsp_tuser,
   input  logic                    rsp_tlast,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_data,
   output int                      fail_count,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumStages = 16;
   localparam logic [23:0] RangeTop = 24'hFF_FFFF;

   typedef struct packed {
      logic        kept;
      logic [23:0] range_m;
      logic [15:0] bearing;
      logic        last;
   } gate_result_type;

   // arctangent steps, one turn is 2^32
   localparam logic [31:0] AtanStep [0:23] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   logic [23:0] win_range_lo, win_range_hi;
   logic [15:0] win_bear_lo, win_bear_hi;
   gate_result_type results_due[$];
   int mismatches;

   function automatic longint unsigned int_root(longint unsigned n);
      longint unsigned rem, res, probe;
      rem   = n;
      res   = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= res + probe) begin
            rem = rem - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   // world angle of the offset by quadrant fold and vectoring steps
   function automatic logic [31:0] world_angle(longint x, longint y);
      longint      t, xs, ys;
      logic [31:0] a;
      a = '0;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; a = 32'h4000_0000;
         end else begin
            t = x; x = -y; y = t; a = 32'hC000_0000;
         end
      end
      x = x * 64;
      y = y * 64;
      for (int i = 0; i < NumStages; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; a = a + AtanStep[i];
         end else begin
            x = x - ys; y = y + xs; a = a - AtanStep[i];
         end
      end
      return a;
   endfunction

   function automatic gate_result_type predict_gate(logic [ReqDataWidth-1:0] d, logic last);
      longint          dx, dy;
      longint unsigned root;
      logic [31:0]     ang;
      logic [15:0]     bcode;
      gate_result_type r;
      dx = longint'($signed(d[23:0])) - longint'($signed(d[71:48]));
      dy = longint'($signed(d[47:24])) - longint'($signed(d[95:72]));
      root = int_root(longint'(dx * dx + dy * dy));
      if (root > RangeTop) root = RangeTop;
      ang   = world_angle(dx, dy) - {d[111:96], 16'h0000};
      bcode = 16'((ang + 32'h8000) >> 16);
      r.range_m = root[23:0];
      r.bearing = bcode;
      r.last    = last;
      r.kept    = (win_range_lo <= root[23:0]) && (root[23:0] <= win_range_hi) &&
                  ($signed(win_bear_lo) <= $signed(bcode)) &&
                  ($signed(bcode) <= $signed(win_bear_hi));
      return r;
   endfunction

   always @(posedge clock) begin
      gate_result_type due, got;
      if (reset) begin
         win_range_lo <= 24'd0;
         win_range_hi <= 24'd15360;
         win_bear_lo  <= 16'hDC72;
         win_bear_hi  <= 16'd9102;
         fail_count   <= 0;
         pending      <= 0;
         mismatches   = 0;
         results_due.delete();
      end else begin
         // register writes: windows take effect for later requests
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_RANGE_MIN:   win_range_lo <= csr_data;
               CSR_RANGE_MAX:   win_range_hi <= csr_data;
               CSR_BEARING_MIN: win_bear_lo  <= csr_data[15:0];
               CSR_BEARING_MAX: win_bear_hi  <= csr_data[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            results_due = {results_due, predict_gate(req_tdata, req_tlast)};
         if (rsp_tvalid && rsp_tready) begin
            got.kept    = rsp_tuser;
            got.range_m = rsp_tdata[23:0];
            got.bearing = rsp_tdata[39:24];
            got.last    = rsp_tlast;
            if (results_due.size() == 0) begin
               fail_count <= fail_count + 1;
               if (mismatches < 10)
                  $display("unexpected response: kept %0b range %0d bearing %0d last %0b",
                           got.kept, got.range_m, $signed(got.bearing), got.last);
               mismatches++;
            end else begin
               due = results_due.pop_front();
               if (due != got) begin
                  fail_count <= fail_count + 1;
                  if (mismatches < 10)
                     $display("mismatch: exp kept %0b range %0d bearing %0d last %0b, %s",
                              due.kept, due.range_m, $signed(due.bearing), due.last,
                              $sformatf("got kept %0b range %0d bearing %0d last %0b",
                                        got.kept, got.range_m, $signed(got.bearing),
                                        got.last));
                  mismatches++;
               end
            end
         end
         pending <= results_due.size();
      end
   end

endmodule

>>> tb/tb.sv
// Stimulus and verdict for landmark_range_bearing_gate_unit: directed and random
// requests over several window settings, random stalls on both sides.
// Depends on lrbg_pkg, the gate RTL and lrbg_checker.
module tb;
   import lrbg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles   = 40;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic                    req_tlast = 1'b0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    rsp_tuser, rsp_tlast, rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   csr_index_type           csr_index = CSR_RANGE_MIN;
   logic [CsrDataWidth-1:0] csr_data = '0;
   int                      fail_count, pending;
   bit                      no_idle = 1'b0;
   bit                      hold_rx = 1'b0;
   bit                      hold_done = 1'b0;
   int                      quiet_cycles = 0;

   always #2 clock = ~clock;

   landmark_range_bearing_gate_unit u_top (.*);

   lrbg_checker u_checker (.*);

   // watchdog on cycles with no traffic at all
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         quiet_cycles <= 0;
      else if (quiet_cycles >= WatchdogLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_rx && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (299) @(negedge clock);
            hold_done = 1'b1;
         end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 7);
            rsp_tready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_landmark(logic [23:0] lx, ly, vx, vy, logic [15:0] head, logic last);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {head, vy, vx, ly, lx};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic sender_gap();
      int n;
      n = $urandom_range(1, 7);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [23:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // only once the pipeline has fully drained
   task automatic set_windows(logic [23:0] rlo, rhi, logic [15:0] blo, bhi);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (DrainCycles) @(posedge clock);
      write_csr(CSR_RANGE_MIN, rlo);
      write_csr(CSR_RANGE_MAX, rhi);
      write_csr(CSR_BEARING_MIN, {8'h00, blo});
      write_csr(CSR_BEARING_MAX, {8'h00, bhi});
   endtask

   // mostly short offsets around the window edges, sometimes anywhere
   task automatic send_random(bit gaps);
      logic [23:0] vx, vy, lx, ly;
      int          kind;
      if (gaps && !no_idle && $urandom_range(0, 9) == 0) sender_gap();
      vx   = 24'($urandom);
      vy   = 24'($urandom);
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
         vx = 24'($signed(vx) >>> 2);
         vy = 24'($signed(vy) >>> 2);
         lx = vx + 24'($urandom_range(0, 40000)) - 24'd20000;
         ly = vy + 24'($urandom_range(0, 40000)) - 24'd20000;
      end else if (kind < 8) begin
         lx = vx + 24'($urandom_range(0, 16)) - 24'd8;
         ly = vy + 24'($urandom_range(0, 16)) - 24'd8;
      end else begin
         lx = 24'($urandom);
         ly = 24'($urandom);
      end
      send_landmark(lx, ly, vx, vy, 16'($urandom), 1'($urandom));
   endtask

   task automatic random_windows();
      logic [23:0] ra, rb;
      logic [15:0] ba, bb;
      ra = 24'($urandom_range(0, 30000));
      rb = ra + 24'($urandom_range(0, 30000));
      ba = 16'($urandom);
      bb = 16'($signed(ba) + $urandom_range(0, 30000));
      if ($signed(bb) < $signed(ba)) bb = 16'h7FFF;
      set_windows(ra, rb, ba, bb);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: default windows
      send_landmark(24'd0, 24'd0, 24'd0, 24'd0, 16'd0, 1'b0);            // zero offset
      send_landmark(24'd5, 24'd9, 24'd5, 24'd9, 16'h7FFF, 1'b1);
      send_landmark(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h8000, 1'b0);
      send_landmark(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 16'd0, 1'b1); // overflow
      send_landmark(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 16'h1234, 1'b0);
      send_landmark(24'h800000, 24'd0, 24'h7FFFFF, 24'd0, 16'd0, 1'b0);
      send_landmark(24'd0, 24'd0, 24'd100, 24'd0, 16'd0, 1'b1);           // bearing at pi
      send_landmark(24'd0, 24'd0, 24'd100, 24'd0, 16'h8000, 1'b0);
      send_landmark(24'd0, 24'd0, 24'd100, 24'd100, 16'd0, 1'b0);
      send_landmark(24'd0, 24'd0, 24'd0, 24'hFFFF9C, 16'd0, 1'b0);
      send_landmark(24'd0, 24'd0, 24'd0, 24'd100, 16'd0, 1'b1);
      send_landmark(24'd15360, 24'd0, 24'd0, 24'd0, 16'd0, 1'b0);          // range edge
      send_landmark(24'd15361, 24'd0, 24'd0, 24'd0, 16'd0, 1'b0);
      send_landmark(24'd10000, 24'd0, 24'd0, 24'd0, 16'd9102, 1'b0);       // bearing edges
      send_landmark(24'd10000, 24'd0, 24'd0, 24'd0, 16'hDC72, 1'b0);
      send_landmark(24'd10000, 24'd0, 24'd0, 24'd0, 16'd9103, 1'b1);
      send_landmark(24'd3, 24'd4, 24'hFFFFFF, 24'hFFFFFF, 16'hC000, 1'b0);
      send_landmark(24'h555555, 24'hAAAAAA, 24'h333333, 24'hCCCCCC, 16'h5A5A, 1'b1);

      set_windows(24'd0, 24'hFFFFFF, 16'h8000, 16'h7FFF);                   // widest
      repeat (220) send_random(1'b1);

      set_windows(24'd5000, 24'd4000, 16'd100, 16'hFF9C);                   // empty windows
      repeat (120) send_random(1'b1);

      // long receiver hold-off with the sender pushing back-to-back
      random_windows();
      hold_rx = 1'b1;
      repeat (120) send_random(1'b0);
      repeat (150) send_random(1'b1);

      set_windows(24'hFFFFFF, 24'hFFFFFF, 16'h8000, 16'h8000);              // top extremes
      repeat (100) send_random(1'b1);

      random_windows();
      repeat (150) send_random(1'b1);

      // last part without idling on either side
      random_windows();
      no_idle = 1'b1;
      repeat (290) send_random(1'b0);

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> landmark_range_bearing_gate_unit.f
hw/rtl/lrbg_pkg.sv
hw/rtl/lrbg_sqrt.sv
hw/rtl/lrbg_cordic.sv
hw/rtl/landmark_range_bearing_gate_unit.sv
hw/rtl/lrbg_checker.sv
tb/lrbg_checker.sv
tb/tb.sv
